FILE: rtl/core/i2ew_pkg.sv
// shared types and constants for the integer to english word token core
package i2ew_pkg;

	localparam int unsigned NUM_W     = 31;
	localparam int unsigned DIG_N     = 10;
	localparam int unsigned BCD_W     = 4 * DIG_N;
	localparam int unsigned CNT_W     = $clog2(NUM_W);
	localparam int unsigned GRP_W     = 2;
	localparam int unsigned WORD_W    = 5;
	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 8;

	localparam logic [CNT_W-1:0]  CONV_LAST = CNT_W'(NUM_W - 1);
	localparam logic [GRP_W-1:0]  GRP_UNITS = 2'd3;

	localparam logic [WORD_W-1:0] TOK_ZERO     = 5'd0;
	localparam logic [WORD_W-1:0] TOK_TEEN0    = 5'd10;
	localparam logic [WORD_W-1:0] TOK_TENS0    = 5'd18;
	localparam logic [WORD_W-1:0] TOK_HUNDRED  = 5'd28;
	localparam logic [WORD_W-1:0] TOK_BILLION  = 5'd31;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV,
		ST_ZERO,
		ST_HUND,
		ST_HWORD,
		ST_TENS,
		ST_ONES,
		ST_SCALE,
		ST_FLUSH
	} state_t;

endpackage

FILE: rtl/core/integer_to_english_word_tokens_core.sv
// integer to english word token core: binary to bcd converter and token sequencer
// Spells an unsigned 31-bit number (low 31 bits of s_tdata) as a run of word tokens on the
// master side, most significant first, with tlast on the final token; zero gives the single
// token zero. One request is taken at a time: it is captured, converted to ten decimal digits
// by a shift-and-add-3 unit that handles one input bit per cycle, then a sequencer walks the
// billion, million, thousand and units groups, one step per cycle while the master side
// accepts: one step for a zero group, up to five for a nonzero group (hundreds digit,
// hundred, tens, ones, scale), followed by a flush step. A stalled master side holds the
// sequencer in its current step.
module integer_to_english_word_tokens_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] number, [31] zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [4:0] word, [7:5] zero fill
	output logic        m_tlast    // last_word
);
	import i2ew_pkg::*;

	state_t              state_q, state_nx;
	logic [NUM_W-1:0]    bin_q;
	logic [BCD_W-1:0]    bcd_q, bcd_adj;
	logic [CNT_W-1:0]    cnt_q;
	logic [GRP_W-1:0]    grp_q;
	logic                zero_q;
	logic                pend_vld_q;
	logic [WORD_W-1:0]   pend_q;
	logic                out_vld_q, out_last_q;
	logic [WORD_W-1:0]   out_word_q;

	logic                adv, accept, mv_out;
	logic                tok_vld, grp_inc;
	logic [WORD_W-1:0]   tok;
	logic [11:0]         grp_bcd;
	logic [3:0]          dig_h, dig_t, dig_o;
	logic                grp_nz;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign adv      = !out_vld_q || m_tready;
	assign mv_out   = adv && ((tok_vld && pend_vld_q) || state_q == ST_FLUSH);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OUT_DATA_W - WORD_W){1'b0}}, out_word_q};
	assign m_tlast  = out_last_q;

	// add-3 correction on every digit before the shift
	always_comb begin
		for (int i = 0; i < DIG_N; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// billion group holds only the top digit
	always_comb begin
		case (grp_q)
			2'd0:    grp_bcd = {8'd0, bcd_q[39:36]};
			2'd1:    grp_bcd = bcd_q[35:24];
			2'd2:    grp_bcd = bcd_q[23:12];
			default: grp_bcd = bcd_q[11:0];
		endcase
	end

	assign dig_h  = grp_bcd[11:8];
	assign dig_t  = grp_bcd[7:4];
	assign dig_o  = grp_bcd[3:0];
	assign grp_nz = (grp_bcd != 12'd0);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_nx = ST_CONV;
			end
			ST_CONV: begin
				if (cnt_q == CONV_LAST) state_nx = zero_q ? ST_ZERO : ST_HUND;
			end
			ST_ZERO: begin
				if (adv) state_nx = ST_FLUSH;
			end
			ST_HUND: begin
				if (adv) begin
					if (!grp_nz) begin
						state_nx = (grp_q == GRP_UNITS) ? ST_FLUSH : ST_HUND;
					end else if (dig_h != 4'd0) begin
						state_nx = ST_HWORD;
					end else begin
						state_nx = ST_TENS;
					end
				end
			end
			ST_HWORD: begin
				if (adv) state_nx = ST_TENS;
			end
			ST_TENS: begin
				if (adv) state_nx = (dig_t >= 4'd2) ? ST_ONES : ST_SCALE;
			end
			ST_ONES: begin
				if (adv) state_nx = ST_SCALE;
			end
			ST_SCALE: begin
				if (adv) state_nx = (grp_q == GRP_UNITS) ? ST_FLUSH : ST_HUND;
			end
			ST_FLUSH: begin
				if (adv) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// token produced by the current sequencer step
	always_comb begin
		tok_vld = 1'b0;
		tok     = TOK_ZERO;
		grp_inc = 1'b0;
		case (state_q)
			ST_ZERO: begin
				tok_vld = 1'b1;
				tok     = TOK_ZERO;
			end
			ST_HUND: begin
				if (!grp_nz) begin
					grp_inc = (grp_q != GRP_UNITS);
				end else if (dig_h != 4'd0) begin
					tok_vld = 1'b1;
					tok     = {1'b0, dig_h};
				end
			end
			ST_HWORD: begin
				tok_vld = 1'b1;
				tok     = TOK_HUNDRED;
			end
			ST_TENS: begin
				if (dig_t >= 4'd2) begin
					tok_vld = 1'b1;
					tok     = TOK_TENS0 + {1'b0, dig_t};
				end else if (dig_t == 4'd1) begin
					tok_vld = 1'b1;
					tok     = TOK_TEEN0 + {1'b0, dig_o};
				end else if (dig_o != 4'd0) begin
					tok_vld = 1'b1;
					tok     = {1'b0, dig_o};
				end
			end
			ST_ONES: begin
				if (dig_o != 4'd0) begin
					tok_vld = 1'b1;
					tok     = {1'b0, dig_o};
				end
			end
			ST_SCALE: begin
				// billion, million, thousand count down from the top code
				tok_vld = (grp_q != GRP_UNITS);
				tok     = TOK_BILLION - {3'd0, grp_q};
				grp_inc = (grp_q != GRP_UNITS);
			end
			default: begin
				tok_vld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (mv_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (adv && tok_vld) begin
				pend_vld_q <= 1'b1;
			end else if (adv && state_q == ST_FLUSH) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q  <= s_tdata[NUM_W-1:0];
			bcd_q  <= '0;
			cnt_q  <= '0;
			grp_q  <= '0;
			zero_q <= (s_tdata[NUM_W-1:0] == '0);
		end else if (state_q == ST_CONV) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[NUM_W-1]};
			bin_q <= {bin_q[NUM_W-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end else if (adv && grp_inc) begin
			grp_q <= grp_q + 1'b1;
		end
		if (adv && tok_vld) begin
			pend_q <= tok;
		end
		if (mv_out) begin
			out_word_q <= pend_q;
			out_last_q <= (state_q == ST_FLUSH);
		end
	end

	// a flush always hands over the final token
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && adv) |=> (state_q == ST_IDLE && m_tvalid && m_tlast))
		else $error("flush did not deliver a last token");

	// a new request never finds a token of the previous one still pending
	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !pend_vld_q)
		else $error("request accepted with a token pending");

	// a non-final token on the output always has a successor held back
	a_nonlast_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> pend_vld_q)
		else $error("non-final token without a pending successor");

	// the flush step is reached only with a token in hand
	a_flush_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> pend_vld_q)
		else $error("flush without a pending token");

endmodule
